@@ sv/sa_pkg.sv @@
`timescale 1ns / 1ps
package sa_pkg;
   localparam int MaxSegmentsDefault = 64;
   localparam int PoolBytesDefault   = 65536;
   localparam int SizeW   = 17;
   localparam int AddrW   = 16;
   localparam int StatusW = 3;
   localparam int CountW  = 7;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_NEXT  = 2'd3
   } fit_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_FIT   = 3'd1,
      ST_BAD_ADDR = 3'd2,
      ST_BAD_SIZE = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SPLIT_RD,
      S_SHIFT_UP,
      S_SPLIT_WR,
      S_MERGE_RD,
      S_MERGE_NXT,
      S_MERGE_PRV,
      S_SHIFT_DN,
      S_STATS,
      S_OUT
   } state_type;

   localparam logic [1:0] REG_FIT  = 2'd0;
   localparam logic [1:0] REG_POOL = 2'd1;
endpackage

@@ sv/sa_seg_mem.sv @@
`timescale 1ns / 1ps
module sa_seg_mem
   import sa_pkg::*;
#(
   parameter int MAX_SEGMENTS = MaxSegmentsDefault,
   parameter int IDX_W        = $clog2(MAX_SEGMENTS),
   parameter int ENT_W        = 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [ENT_W-1:0] wr_data,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [ENT_W-1:0] rd_data
);
   logic [ENT_W-1:0] mem_ff [MAX_SEGMENTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
      rd_data <= mem_ff[rd_idx];
   end
endmodule

@@ sv/segment_allocator_fit_policies_unit.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// req_      in         tdata: opcode[1:0], request_size[18:2], address[34:19]
// rsp_      out        tdata: status, granted_address, small_hole_count, free_bytes,
//                      allocated_bytes, hole_count, largest_hole
// csr_      in         APB: 0x0 fit_mode, 0x4 pool_bytes
// A request runs only the statistics pass (query, zero size, unused opcode), or a
// scan, a shift of the table and the statistics pass as needed. Memory reads are
// registered: a scan or statistics pass reads one entry per cycle, a shift reads
// each entry and then writes it before it takes the next.
// Reset (or a pool_bytes write) leaves one free segment spanning the pool.
// req_tready is low from acceptance until the result beat is taken.
module segment_allocator_fit_policies_unit
   import sa_pkg::*;
#(
   parameter int MAX_SEGMENTS = MaxSegmentsDefault,
   parameter int POOL_BYTES   = PoolBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // opcode, request_size, address
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // status, granted_address, small_hole_count,
                                    // free_bytes, allocated_bytes, hole_count,
                                    // largest_hole
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int IW   = $clog2(MAX_SEGMENTS);
   localparam int CW   = $clog2(MAX_SEGMENTS + 1);
   localparam int EW   = 2 * SizeW + 1;
   localparam logic [CW-1:0] MaxCnt = CW'(MAX_SEGMENTS);
   localparam logic [SizeW-1:0] PoolMax = SizeW'(POOL_BYTES);

   // entry: {alloc, start, size}
   fit_type            fit_ff;
   logic [SizeW-1:0]   pool_ff;
   logic [CW-1:0]      cnt_ff;
   logic [IW-1:0]      rover_ff;
   state_type          st_ff, st_in;

   opcode_type         op_ff;
   logic [SizeW-1:0]   rsz_ff;
   logic [AddrW-1:0]   addr_ff;
   logic [CW-1:0]      i_ff, i_in;       // issued read index
   logic [CW-1:0]      k_ff, k_in;       // index of data arriving
   logic               dv_ff, dv_in;
   logic               found_ff, found_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [SizeW-1:0]   slack_ff, slack_in;
   logic [EW-1:0]      sel_ff, sel_in;   // chosen entry
   logic [EW-1:0]      nb_ff, nb_in;     // neighbor scratch
   logic [EW-1:0]      pr_ff, pr_in;     // previous entry during scan
   logic [EW-1:0]      mv_ff, mv_in;     // shift carry
   logic [CW-1:0]      end_ff, end_in;
   status_type         stat_ff, stat_in;
   logic [AddrW-1:0]   gr_ff, gr_in;
   logic [CountW-1:0]  sm_ff, sm_in, hc_ff, hc_in;
   logic [SizeW-1:0]   fb_ff, fb_in, ab_ff, ab_in, lg_ff, lg_in;
   logic [CW-1:0]      cnt_in;
   logic [IW-1:0]      rover_in;

   logic               we;
   logic [IW-1:0]      widx, ridx;
   logic [EW-1:0]      wdat, rdat;

   sa_seg_mem #(.MAX_SEGMENTS(MAX_SEGMENTS), .IDX_W(IW), .ENT_W(EW)) u_mem (
      .clock(clock), .wr_en(we), .wr_idx(widx), .wr_data(wdat),
      .rd_idx(ridx), .rd_data(rdat)
   );

   logic               cfg_wr;
   logic [SizeW-1:0]   cfg_pool;
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      cfg_pool = csr_pwdata[SizeW-1:0];
      if (cfg_pool == '0) cfg_pool = SizeW'(1);
      if (cfg_pool > PoolMax) cfg_pool = PoolMax;
      csr_prdata = '0;
      if (csr_paddr[2] == REG_POOL[0]) csr_prdata[SizeW-1:0] = pool_ff;
      else csr_prdata[1:0] = fit_ff;
   end

   logic          e_al;
   logic [SizeW-1:0] e_st, e_sz, d;
   logic          fits;
   assign e_al = rdat[EW-1];
   assign e_st = rdat[2*SizeW-1:SizeW];
   assign e_sz = rdat[SizeW-1:0];
   assign fits = !e_al && e_sz >= rsz_ff;
   assign d    = e_sz - rsz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         fit_ff <= FIT_FIRST;
         pool_ff <= PoolMax;
         cnt_ff <= CW'(1);
         rover_ff <= '0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         rover_ff <= rover_in;
         if (cfg_wr && csr_paddr[2] == REG_FIT[0]) fit_ff <= fit_type'(csr_pwdata[1:0]);
         if (cfg_wr && csr_paddr[2] == REG_POOL[0]) begin
            pool_ff <= cfg_pool;
            cnt_ff <= CW'(1);
            rover_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff   <= opcode_type'(req_tdata[1:0]);
         rsz_ff  <= req_tdata[18:2];
         addr_ff <= req_tdata[34:19];
      end
      i_ff <= i_in; k_ff <= k_in; dv_ff <= dv_in;
      found_ff <= found_in; idx_ff <= idx_in; slack_ff <= slack_in;
      sel_ff <= sel_in; nb_ff <= nb_in; pr_ff <= pr_in; mv_ff <= mv_in;
      end_ff <= end_in; stat_ff <= stat_in; gr_ff <= gr_in;
      sm_ff <= sm_in; hc_ff <= hc_in; fb_ff <= fb_in; ab_ff <= ab_in; lg_ff <= lg_in;
   end

   // Entry 0 lives in memory; after reset or a pool reinit it is rewritten on every
   // idle cycle until the next request is taken.
   logic init_ff;
   always_ff @(posedge clock) begin
      if (reset) init_ff <= 1'b1;
      else if (cfg_wr && csr_paddr[2] == REG_POOL[0]) init_ff <= 1'b1;
      else if (st_ff == S_IDLE && req_tvalid) init_ff <= 1'b0;
   end

   logic [CW-1:0] next_k;
   always_comb begin
      st_in = st_ff; i_in = i_ff; k_in = k_ff; dv_in = 1'b0;
      found_in = found_ff; idx_in = idx_ff; slack_in = slack_ff;
      sel_in = sel_ff; nb_in = nb_ff; pr_in = pr_ff; mv_in = mv_ff;
      end_in = end_ff; stat_in = stat_ff; gr_in = gr_ff;
      sm_in = sm_ff; hc_in = hc_ff; fb_in = fb_ff; ab_in = ab_ff; lg_in = lg_ff;
      cnt_in = cnt_ff; rover_in = rover_ff;
      we = 1'b0; widx = '0; wdat = '0; ridx = i_ff[IW-1:0];
      req_tready = 1'b0; rsp_tvalid = 1'b0;
      next_k = k_ff + CW'(1);
      unique case (st_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (init_ff) begin
               we = 1'b1; widx = '0; wdat = {1'b0, {SizeW{1'b0}}, pool_ff};
            end
            if (req_tvalid) begin
               i_in = '0; found_in = 1'b0; stat_in = ST_OK; gr_in = '0;
               slack_in = '0; idx_in = '0;
               unique case (opcode_type'(req_tdata[1:0]))
                  OP_ALLOC: begin
                     if (req_tdata[18:2] == '0) begin
                        stat_in = ST_BAD_SIZE; st_in = S_STATS;
                     end else begin
                        st_in = S_SCAN;
                        if (fit_ff == FIT_NEXT)
                           i_in = (CW'(rover_ff) < cnt_ff) ? CW'(rover_ff) : '0;
                     end
                     end_in = i_in;
                  end
                  OP_FREE:  st_in = S_SCAN;
                  default:  st_in = S_STATS;
               endcase
               k_in = i_in;
               if (st_in == S_STATS) begin
                  i_in = '0; k_in = '0;
                  sm_in = '0; hc_in = '0; fb_in = '0; ab_in = '0; lg_in = '0;
               end
            end
         end
         S_SCAN: begin
            // One read issued per cycle; data for k_ff arrives when dv_ff.
            if (!dv_ff) begin
               ridx = i_ff[IW-1:0]; dv_in = 1'b1; k_in = i_ff;
            end else begin
               ridx = k_ff[IW-1:0];
               if (op_ff == OP_FREE) begin
                  if (addr_ff >= e_st[AddrW-1:0] && e_st <= SizeW'(addr_ff) &&
                      SizeW'(addr_ff) - e_st < e_sz) begin
                     found_in = 1'b1; idx_in = k_ff[IW-1:0]; sel_in = rdat;
                     st_in = S_DECIDE;
                  end else begin
                     pr_in = rdat;
                     if (next_k >= cnt_ff) st_in = S_DECIDE;
                     else begin k_in = next_k; i_in = next_k; end
                  end
               end else begin
                  if (fits && (!found_ff || (fit_ff == FIT_BEST && d < slack_ff) ||
                               (fit_ff == FIT_WORST && d > slack_ff))) begin
                     found_in = 1'b1; idx_in = k_ff[IW-1:0]; sel_in = rdat;
                     slack_in = d;
                  end
                  if (next_k >= cnt_ff) next_k = '0;
                  if ((fits && (fit_ff == FIT_FIRST || fit_ff == FIT_NEXT)) ||
                      next_k == end_ff) st_in = S_DECIDE;
                  else begin k_in = next_k; i_in = next_k; end
               end
               if (st_in != S_DECIDE) begin
                  ridx = k_in[IW-1:0]; dv_in = 1'b1;
               end
            end
         end
         S_DECIDE: begin
            if (op_ff == OP_ALLOC) begin
               if (!found_ff) begin
                  stat_in = ST_NO_FIT; st_in = S_STATS;
               end else if (sel_ff[SizeW-1:0] != rsz_ff) begin
                  if (cnt_ff >= MaxCnt) begin
                     stat_in = ST_FULL; st_in = S_STATS;
                  end else begin
                     // Split: write allocated head, then shift tail up inserting remainder.
                     we = 1'b1; widx = idx_ff;
                     wdat = {1'b1, sel_ff[2*SizeW-1:SizeW], rsz_ff};
                     mv_in = {1'b0, sel_ff[2*SizeW-1:SizeW] + rsz_ff,
                              sel_ff[SizeW-1:0] - rsz_ff};
                     k_in = CW'(idx_ff) + CW'(1);
                     gr_in = sel_ff[SizeW+AddrW-1:SizeW];
                     cnt_in = cnt_ff + CW'(1);
                     rover_in = idx_ff + IW'(1);
                     st_in = S_SHIFT_UP; dv_in = 1'b0;
                  end
               end else begin
                  we = 1'b1; widx = idx_ff; wdat = {1'b1, sel_ff[EW-2:0]};
                  gr_in = sel_ff[SizeW+AddrW-1:SizeW];
                  rover_in = (CW'(idx_ff) + CW'(1) < cnt_ff) ? idx_ff + IW'(1) : '0;
                  st_in = S_STATS;
               end
            end else begin
               if (!found_ff || !sel_ff[EW-1]) begin
                  stat_in = ST_BAD_ADDR; st_in = S_STATS;
               end else begin
                  sel_in = {1'b0, sel_ff[EW-2:0]};
                  ridx = idx_ff + IW'(1);
                  st_in = S_MERGE_RD;
               end
            end
            if (st_in == S_STATS) begin
               i_in = '0; k_in = '0; dv_in = 1'b0;
               sm_in = '0; hc_in = '0; fb_in = '0; ab_in = '0; lg_in = '0;
            end
         end
         S_SHIFT_UP: begin
            // Read entry k, write carry at k, carry becomes old entry.
            if (!dv_ff) begin
               if (k_ff >= cnt_ff - CW'(1)) begin
                  we = 1'b1; widx = k_ff[IW-1:0]; wdat = mv_ff;
                  st_in = S_STATS; i_in = '0; k_in = '0;
                  sm_in = '0; hc_in = '0; fb_in = '0; ab_in = '0; lg_in = '0;
               end else begin
                  ridx = k_ff[IW-1:0]; dv_in = 1'b1;
               end
            end else begin
               we = 1'b1; widx = k_ff[IW-1:0]; wdat = mv_ff;
               mv_in = rdat; k_in = next_k;
            end
         end
         S_MERGE_RD: begin
            // rdat is entry idx+1 (garbage if beyond end).
            nb_in = rdat;
            ridx = idx_ff - IW'(1);
            st_in = S_MERGE_NXT;
         end
         S_MERGE_NXT: begin
            // rdat is entry idx-1.
            pr_in = rdat;
            end_in = '0;  // number of entries to remove
            k_in = CW'(idx_ff);
            if (CW'(idx_ff) + CW'(1) < cnt_ff && !nb_ff[EW-1]) begin
               sel_in = {1'b0, sel_ff[2*SizeW-1:SizeW], sel_ff[SizeW-1:0] + nb_ff[SizeW-1:0]};
               end_in = CW'(1);
            end
            st_in = S_MERGE_PRV;
         end
         S_MERGE_PRV: begin
            if (idx_ff != '0 && !pr_ff[EW-1]) begin
               we = 1'b1; widx = idx_ff - IW'(1);
               wdat = {1'b0, pr_ff[2*SizeW-1:SizeW], pr_ff[SizeW-1:0] + sel_ff[SizeW-1:0]};
               k_in = CW'(idx_ff);
               end_in = end_ff + CW'(1);
            end else begin
               we = 1'b1; widx = idx_ff; wdat = sel_ff;
               k_in = CW'(idx_ff) + CW'(1);
            end
            // Rover adjust: each removed entry at r sits at index >= k_in.
            begin
               logic [CW-1:0] r; logic [CW-1:0] c;
               r = CW'(rover_ff); c = cnt_ff;
               if (end_ff != '0) begin  // remove idx+1
                  c = c - CW'(1);
                  if (r >= CW'(idx_ff) + CW'(1) && r > '0) r = r - CW'(1);
                  if (r >= c) r = '0;
               end
               if (idx_ff != '0 && !pr_ff[EW-1]) begin
                  c = c - CW'(1);
                  if (r >= CW'(idx_ff) && r > '0) r = r - CW'(1);
                  if (r >= c) r = '0;
               end
               rover_in = r[IW-1:0];
               cnt_in = c;
            end
            dv_in = 1'b0;
            st_in = (end_in == '0) ? S_STATS : S_SHIFT_DN;
            if (st_in == S_STATS) begin
               i_in = '0; k_in = '0;
               sm_in = '0; hc_in = '0; fb_in = '0; ab_in = '0; lg_in = '0;
            end
         end
         S_SHIFT_DN: begin
            // Copy entry k+end to k, for k below new count.
            if (k_ff >= cnt_ff) begin
               st_in = S_STATS; i_in = '0; k_in = '0; dv_in = 1'b0;
               sm_in = '0; hc_in = '0; fb_in = '0; ab_in = '0; lg_in = '0;
            end else if (!dv_ff) begin
               ridx = IW'(k_ff + end_ff); dv_in = 1'b1;
            end else begin
               we = 1'b1; widx = k_ff[IW-1:0]; wdat = rdat; k_in = next_k;
            end
         end
         S_STATS: begin
            if (dv_ff) begin
               if (e_al) ab_in = ab_ff + e_sz;
               else begin
                  fb_in = fb_ff + e_sz; hc_in = hc_ff + CountW'(1);
                  if (e_sz > lg_ff) lg_in = e_sz;
                  if (op_ff == OP_QUERY && e_sz <= rsz_ff) sm_in = sm_ff + CountW'(1);
               end
               k_in = next_k;
            end
            if (i_ff < cnt_ff) begin
               ridx = i_ff[IW-1:0]; dv_in = 1'b1; i_in = i_ff + CW'(1);
            end else if (!dv_ff) st_in = S_OUT;
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   assign rsp_tdata = {4'd0, lg_ff, hc_ff, ab_ff, fb_ff, sm_ff,
                       (stat_ff == ST_OK) ? gr_ff : {AddrW{1'b0}}, stat_ff};

   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("ready while a result is pending");
   assert property (@(posedge clock) disable iff (reset) cnt_ff != '0 && cnt_ff <= MaxCnt)
      else $error("segment count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] == ST_OK) |-> (rsp_tdata[59:43] + rsp_tdata[42:26]) == pool_ff)
      else $error("byte totals do not cover the pool");
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import sa_pkg::*;

   localparam int NumSegs = 64;
   localparam int PoolMax = 65536;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] granted;
      logic [6:0]  small_holes;
      logic [16:0] free_b;
      logic [16:0] alloc_b;
      logic [6:0]  holes;
      logic [16:0] largest;
   } alloc_result_type;

   typedef struct {
      opcode_type  op;
      logic [16:0] size;
      logic [15:0] addr;
      bit          has_status;
      status_type  want_status;
   } stim_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [87:0] rsp_tdata;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   segment_allocator_fit_policies_unit dut (.*);

   always #4 clock = ~clock;

   // Shadow copy of the segment table.
   int unsigned seg_start[NumSegs];
   int unsigned seg_size[NumSegs];
   bit          seg_used[NumSegs];
   int unsigned seg_total;
   int unsigned rover;
   fit_type     mode;
   int unsigned pool_size;

   alloc_result_type pending_results[$];
   int unsigned   live_addrs[$];
   int            error_count = 0;
   int            beats_checked = 0;
   bit            calm = 0;

   function automatic void pool_reinit();
      seg_total = 1;
      seg_start[0] = 0;
      seg_size[0] = pool_size;
      seg_used[0] = 0;
      rover = 0;
   endfunction

   function automatic void drop_entry(int unsigned r);
      for (int unsigned i = r; i + 1 < seg_total; i++) begin
         seg_start[i] = seg_start[i + 1];
         seg_size[i] = seg_size[i + 1];
         seg_used[i] = seg_used[i + 1];
      end
      seg_total--;
      if (rover >= r && rover > 0) rover--;
      if (rover >= seg_total) rover = 0;
   endfunction

   function automatic int unsigned grant_block(int unsigned want, output int unsigned where);
      int unsigned idx = 0, slack = 0, i, d, s;
      bit found = 0;
      where = 0;
      if (want == 0) return ST_BAD_SIZE;
      if (mode == FIT_NEXT) begin
         s = (rover < seg_total) ? rover : 0;
         for (int unsigned k = 0; k < seg_total && !found; k++) begin
            i = s + k;
            if (i >= seg_total) i -= seg_total;
            if (!seg_used[i] && seg_size[i] >= want) begin
               idx = i;
               found = 1;
            end
         end
      end else begin
         for (i = 0; i < seg_total; i++) begin
            if (seg_used[i] || seg_size[i] < want) continue;
            d = seg_size[i] - want;
            if (!found || (mode == FIT_BEST && d < slack) ||
                (mode == FIT_WORST && d > slack)) begin
               idx = i;
               slack = d;
               found = 1;
               if (mode == FIT_FIRST) break;
            end
         end
      end
      if (!found) return ST_NO_FIT;
      if (seg_size[idx] != want) begin
         if (seg_total >= NumSegs) return ST_FULL;
         for (i = seg_total; i > idx + 1; i--) begin
            seg_start[i] = seg_start[i - 1];
            seg_size[i] = seg_size[i - 1];
            seg_used[i] = seg_used[i - 1];
         end
         seg_start[idx + 1] = seg_start[idx] + want;
         seg_size[idx + 1] = seg_size[idx] - want;
         seg_used[idx + 1] = 0;
         seg_total++;
         seg_size[idx] = want;
      end
      seg_used[idx] = 1;
      rover = (idx + 1 < seg_total) ? idx + 1 : 0;
      where = seg_start[idx];
      return ST_OK;
   endfunction

   function automatic int unsigned release_block(int unsigned a);
      int unsigned i;
      for (i = 0; i < seg_total; i++)
         if (a >= seg_start[i] && a - seg_start[i] < seg_size[i]) break;
      if (i >= seg_total || !seg_used[i]) return ST_BAD_ADDR;
      seg_used[i] = 0;
      if (i + 1 < seg_total && !seg_used[i + 1]) begin
         seg_size[i] += seg_size[i + 1];
         drop_entry(i + 1);
      end
      if (i > 0 && !seg_used[i - 1]) begin
         seg_size[i - 1] += seg_size[i];
         drop_entry(i);
      end
      return ST_OK;
   endfunction

   function automatic alloc_result_type predict_alloc(opcode_type op, int unsigned size,
                                                       int unsigned a);
      alloc_result_type r;
      int unsigned st = ST_OK, g = 0, sm = 0, fb = 0, ab = 0, h = 0, lg = 0;
      if (op == OP_ALLOC) begin
         st = grant_block(size, g);
         if (st != ST_OK) g = 0;
         else live_addrs.push_back(g);
      end else if (op == OP_FREE) begin
         st = release_block(a);
      end
      for (int unsigned i = 0; i < seg_total; i++) begin
         if (seg_used[i]) ab += seg_size[i];
         else begin
            fb += seg_size[i];
            h++;
            if (seg_size[i] > lg) lg = seg_size[i];
            if (op == OP_QUERY && seg_size[i] <= size) sm++;
         end
      end
      r.status = 3'(st); r.granted = 16'(g); r.small_holes = 7'(sm); r.free_b = 17'(fb);
      r.alloc_b = 17'(ab); r.holes = 7'(h); r.largest = 17'(lg);
      return r;
   endfunction

   task automatic csr_write(logic [1:0] idx, int unsigned value);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx[0], 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (idx == REG_FIT) mode = fit_type'(value[1:0]);
      else begin
         pool_size = value & 32'h1FFFF;
         if (pool_size < 1) pool_size = 1;
         if (pool_size > PoolMax) pool_size = PoolMax;
         pool_reinit();
         live_addrs.delete();
      end
   endtask

   // Valid stays high after a beat is taken until the next beat or an idle cycle.
   task automatic send_request(opcode_type op, int unsigned size, int unsigned a);
      while (!calm && $urandom_range(99) < 12) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      pending_results.push_back(predict_alloc(op, size & 32'h1FFFF, a & 32'hFFFF));
      req_tvalid <= 1;
      req_tdata <= {5'b0, a[15:0], size[16:0], op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // The receiver stalls at random outside calm stretches; the beat is taken on a clean edge.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= calm || ($urandom_range(99) >= 12);
   end

   always @(posedge clock) begin
      alloc_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[2:0];
         got.granted = rsp_tdata[18:3];
         got.small_holes = rsp_tdata[25:19];
         got.free_b = rsp_tdata[42:26];
         got.alloc_b = rsp_tdata[59:43];
         got.holes = rsp_tdata[66:60];
         got.largest = rsp_tdata[83:67];
         beats_checked++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected st=%0d g=%0h sm=%0d fb=%0d ab=%0d h=%0d lg=%0d",
                        $time, want.status, want.granted, want.small_holes, want.free_b,
                        want.alloc_b, want.holes, want.largest);
               $display("%0t:          actual   st=%0d g=%0h sm=%0d fb=%0d ab=%0d h=%0d lg=%0d",
                        $time, got.status, got.granted, got.small_holes, got.free_b,
                        got.alloc_b, got.holes, got.largest);
               error_count++;
            end
         end
      end
   end

   stim_row_type directed_rows[] = '{
      '{OP_QUERY, 17'd65536, 16'd0, 1, ST_OK},
      '{OP_ALLOC, 17'd0, 16'd0, 1, ST_BAD_SIZE},
      '{OP_FREE, 17'd0, 16'd0, 1, ST_BAD_ADDR},
      '{OP_FREE, 17'd0, 16'd65535, 1, ST_BAD_ADDR},
      '{OP_ALLOC, 17'd65536, 16'd0, 1, ST_OK},
      '{OP_ALLOC, 17'd1, 16'd0, 1, ST_NO_FIT},
      '{OP_FREE, 17'd0, 16'd65535, 1, ST_OK},
      '{OP_ALLOC, 17'd100, 16'd0, 0, ST_OK},
      '{OP_ALLOC, 17'd20, 16'd0, 0, ST_OK},
      '{OP_ALLOC, 17'd50, 16'd0, 0, ST_OK},
      '{OP_ALLOC, 17'd30, 16'd0, 0, ST_OK},
      '{OP_FREE, 17'd0, 16'd100, 0, ST_OK},
      '{OP_FREE, 17'd0, 16'd170, 0, ST_OK},
      '{OP_FREE, 17'd0, 16'd120, 1, ST_OK},
      '{OP_QUERY, 17'd20, 16'd0, 0, ST_OK},
      '{OP_ALLOC, 17'd20, 16'd0, 0, ST_OK},
      '{OP_NONE, 17'h1FFFF, 16'hFFFF, 1, ST_OK},
      '{OP_QUERY, 17'd0, 16'd0, 0, ST_OK},
      '{OP_ALLOC, 17'h1FFFF, 16'd0, 1, ST_NO_FIT}
   };

   task automatic random_phase(int unsigned count, int unsigned max_req);
      int unsigned k, roll, a;
      for (k = 0; k < count; k++) begin
         calm = (k >= count / 2 && k < count / 2 + 60);
         roll = $urandom_range(99);
         if (roll < 50) begin
            // Mostly small sizes, now and then one of any size up to the whole pool, which may miss.
            send_request(OP_ALLOC, ($urandom_range(15) == 0) ?
                         $urandom_range(PoolMax, 0) : $urandom_range(max_req, 1), 0);
         end else if (roll < 85 && live_addrs.size() != 0) begin
            a = $urandom_range(live_addrs.size() - 1);
            send_request(OP_FREE, $urandom, live_addrs[a] + $urandom_range(1, 0));
            live_addrs.delete(a);
         end else if (roll < 92) begin
            send_request(OP_FREE, $urandom, $urandom_range(65535));
         end else begin
            send_request(opcode_type'($urandom_range(3, 2)), $urandom_range(PoolMax), $urandom);
         end
      end
      calm = 0;
   endtask

   initial begin
      mode = FIT_FIRST;
      pool_size = PoolMax;
      pool_reinit();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed_rows[r]) begin
         send_request(directed_rows[r].op, directed_rows[r].size, directed_rows[r].addr);
         if (directed_rows[r].has_status &&
             pending_results[$].status != directed_rows[r].want_status) begin
            $display("%0t: row %0d expected status %0d, predicted %0d", $time, r,
                     directed_rows[r].want_status, pending_results[$].status);
            error_count++;
         end
      end
      drain_results();
      // A write of zero clamps the pool to its smallest size of one byte.
      csr_write(REG_POOL, 0);
      send_request(OP_ALLOC, 1, 0);
      send_request(OP_QUERY, 1, 0);
      drain_results();
      for (int p = 0; p < 4; p++) begin
         drain_results();
         csr_write(REG_FIT, p);
         csr_write(REG_POOL, (p == 0) ? 200 : (p == 3) ? 65536 : $urandom_range(4000, 100));
         random_phase(220, (p == 0) ? 8 : 600);
      end
      drain_results();
      csr_write(REG_FIT, FIT_NEXT);
      csr_write(REG_POOL, 32'h1FFFF);
      random_phase(120, 2000);
      drain_results();
      $display("Covered %0d checked beats over all fit policies and pool sizes 1..65536,",
               beats_checked);
      $display("including table-full, no-fit, bad free and merge cases.");
      if (error_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   initial begin
      #40ms;
      $display("tb_top: errors");
      $finish;
   end
endmodule
